FILE: rtl/sscnt_pkg.sv
// ============================================================================
// sscnt_pkg: shared definitions for the sorted source counter table
// Word widths, default sizes and the structs passed between the cells, the
// match reduction stages and the control logic.
// ============================================================================
package sscnt_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned DEF_CAPACITY = 256;
  // Number of cell matches merged by each unit of the first registered merge stage.
  localparam int unsigned MERGE_GROUP  = 16;

  localparam logic [WORD_W-1:0] COUNT_MAX = '1;
  localparam logic [WORD_W-1:0] COUNT_ONE = WORD_W'(1);

  // Commands broadcast to every cell of the row.
  typedef struct packed {
    logic cmp;   // compare the stored address with the key
    logic hit;   // bump the count of the matching cell
    logic ins;   // insert the key at its sorted place, shifting upwards
  } cell_cmd_t;

  // One match report: the flag and the count after the bump, zero if no hit.
  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] count;
  } match_t;

endpackage

FILE: rtl/sorted_source_counter_table.sv
// ============================================================================
// sorted_source_counter_table: per-source packet counter over a sorted table
// Counts packets per 32-bit source address in a row of cells kept in
// ascending address order, inserting unknown addresses at their place while room is left.
// ============================================================================
//
// Usage. Each input word on s_axis carries one packet source address. For
// every accepted word exactly one result word leaves on m_axis: the count of
// that address after the update in tdata, and two flags in tuser saying
// whether the address was newly inserted or whether it was unknown and the
// table had no room left (count then reads 0).
//
// Sequence. The input is taken in the idle state. The word then passes the key
// compare in the cell row and the two registered stages of the match merge
// tree, after which the cells are updated and the result is registered. A
// new word is accepted only once the previous one has been applied.
//
// Stalls. The result sits in an output register. While it waits for m_axis
// the next word may be accepted and searched; its update and result are held
// until the output register has been emptied.
//
// Reset. rst clears the fill count, the sequencer and the output valid. The
// cell contents are not cleared: cells at or above the fill count are
// ignored, so the table is empty straight after reset.
// ============================================================================
module sorted_source_counter_table
  import sscnt_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [WORD_W-1:0] s_axis_tdata,   // [31:0] source_address
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [WORD_W-1:0] m_axis_tdata,   // [31:0] packet_count
  output logic [1:0]        m_axis_tuser    // [0] new_entry, [1] table_full
);

  localparam int unsigned TOTAL_W = $clog2(CAPACITY + 1);
  localparam int unsigned NGROUP  = (CAPACITY + MERGE_GROUP - 1) / MERGE_GROUP;
  localparam int unsigned NPAD    = NGROUP * MERGE_GROUP;

  // Sequencer: idle, compare, two merge stages, apply.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CMP   = 5'b00010,
    ST_SUM1  = 5'b00100,
    ST_SUM2  = 5'b01000,
    ST_APPLY = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [WORD_W-1:0]    key;
  logic [TOTAL_W-1:0]   total;
  logic                 apply_go;
  logic                 table_at_cap;
  cell_cmd_t            cmd;

  logic [WORD_W-1:0]    cell_addr  [CAPACITY];
  logic [WORD_W-1:0]    cell_count [CAPACITY];
  logic                 cell_lt    [CAPACITY];
  match_t               cell_match [NPAD];
  match_t               group_match [NGROUP];
  match_t               final_match;

  assign s_axis_tready = (state == ST_IDLE);
  assign table_at_cap  = (total == TOTAL_W'(CAPACITY));
  // The update only goes ahead once the previous result has been taken.
  assign apply_go      = (state == ST_APPLY) && (!m_axis_tvalid || m_axis_tready);

  assign cmd.cmp = (state == ST_CMP);
  assign cmd.hit = apply_go && final_match.hit;
  assign cmd.ins = apply_go && !final_match.hit && !table_at_cap;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_CMP;
      ST_CMP:   state_next = ST_SUM1;
      ST_SUM1:  state_next = ST_SUM2;
      ST_SUM2:  state_next = ST_APPLY;
      ST_APPLY: if (apply_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      total         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ins) begin
        total <= total + TOTAL_W'(1);
      end
      if (apply_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Key and result payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key <= s_axis_tdata;
    end
    if (apply_go) begin
      if (final_match.hit) begin
        m_axis_tdata <= final_match.count;
        m_axis_tuser <= 2'b00;
      end else if (table_at_cap) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 2'b10;
      end else begin
        m_axis_tdata <= COUNT_ONE;
        m_axis_tuser <= 2'b01;
      end
    end
  end

  // Row of cells; on insertion the key fills its place, those above shift up.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              live;
    logic              prev_lt;
    logic [WORD_W-1:0] prev_addr;
    logic [WORD_W-1:0] prev_count;

    assign live = (TOTAL_W'(i) < total);

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_addr  = '0;
      assign prev_count = '0;
    end else begin : g_rest
      assign prev_lt    = cell_lt[i-1];
      assign prev_addr  = cell_addr[i-1];
      assign prev_count = cell_count[i-1];
    end

    sscnt_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .key        (key),
      .live       (live),
      .prev_lt    (prev_lt),
      .prev_addr  (prev_addr),
      .prev_count (prev_count),
      .addr       (cell_addr[i]),
      .count      (cell_count[i]),
      .lt         (cell_lt[i]),
      .match      (cell_match[i])
    );
  end

  for (genvar i = CAPACITY; i < NPAD; i++) begin : g_pad
    assign cell_match[i] = '0;
  end

  // Two registered merge stages gather the single possible hit.
  for (genvar g = 0; g < NGROUP; g++) begin : g_group
    match_t group_in [MERGE_GROUP];

    for (genvar j = 0; j < MERGE_GROUP; j++) begin : g_slice
      assign group_in[j] = cell_match[g*MERGE_GROUP + j];
    end

    sscnt_merge #(
      .WIDTH (MERGE_GROUP)
    ) u_merge (
      .clk       (clk),
      .in_match  (group_in),
      .out_match (group_match[g])
    );
  end

  sscnt_merge #(
    .WIDTH (NGROUP)
  ) u_merge_final (
    .clk       (clk),
    .in_match  (group_match),
    .out_match (final_match)
  );

endmodule

FILE: rtl/sscnt_cell.sv
// ============================================================================
// sscnt_cell: one entry of the sorted table
// Holds an address and its count, compares against the broadcast key, stores
// the key at its place or takes its lower neighbour's entry on an insertion.
// ============================================================================
module sscnt_cell
  import sscnt_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [WORD_W-1:0] key,
  input  logic              live,        // entry index is below the fill count
  input  logic              prev_lt,     // lower neighbour holds an address below key
  input  logic [WORD_W-1:0] prev_addr,
  input  logic [WORD_W-1:0] prev_count,
  output logic [WORD_W-1:0] addr,
  output logic [WORD_W-1:0] count,
  output logic              lt,
  output match_t            match
);

  logic              eq;
  logic [WORD_W-1:0] count_inc;

  assign count_inc   = (count == COUNT_MAX) ? count : count + COUNT_ONE;
  assign match.hit   = eq;
  assign match.count = eq ? count_inc : '0;

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      lt <= live && (addr < key);
      eq <= live && (addr == key);
    end
    if (cmd.hit && eq) begin
      count <= count_inc;
    end
    if (cmd.ins) begin
      if (!prev_lt) begin
        addr  <= prev_addr;
        count <= prev_count;
      end else if (!lt) begin
        addr  <= key;
        count <= COUNT_ONE;
      end
    end
  end

endmodule

FILE: rtl/sscnt_merge.sv
// ============================================================================
// sscnt_merge: registered merge of match reports
// ORs a group of match reports into one; at most one input ever hits.
// ============================================================================
module sscnt_merge
  import sscnt_pkg::*;
#(
  parameter int unsigned WIDTH = MERGE_GROUP
) (
  input  logic             clk,
  input  match_t           in_match [WIDTH],
  output match_t           out_match
);

  match_t merged;

  always_comb begin
    merged = '0;
    for (int i = 0; i < WIDTH; i++) begin
      merged = merged | in_match[i];
    end
  end

  always_ff @(posedge clk) begin
    out_match <= merged;
  end

endmodule
